### sv/gsm_pkg.sv
`default_nettype none
package gsm_pkg;

	localparam int MAX_PAIRS    = 256;
	localparam int MAX_CLUSTERS = 32;
	localparam int MAX_FLASHES  = 64;

	localparam int CLUSTER_W = 5;
	localparam int FLASH_W   = 6;
	localparam int SCORE_W   = 32;

	localparam int ADDR_W = $clog2(MAX_PAIRS);
	localparam int CNT_W  = $clog2(MAX_PAIRS + 1);

	typedef struct packed {
		logic [CLUSTER_W-1:0]      cluster;
		logic [FLASH_W-1:0]        flash;
		logic signed [SCORE_W-1:0] score;
	} pair_t;

	typedef struct packed {
		logic  found;
		pair_t pair;
	} best_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DECIDE
	} state_t;

endpackage
`default_nettype wire

### sv/gsm_best_unit.sv
`default_nettype none
module gsm_best_unit import gsm_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    clr,
	input  wire logic                    smp_vld,
	input  wire pair_t                   smp,
	input  wire logic [MAX_CLUSTERS-1:0] cl_used,
	input  wire logic [MAX_FLASHES-1:0]  fl_used,
	input  wire logic                    reuse,
	output best_t                        best
);

	logic  elig;
	logic  take;
	logic  found_q;
	pair_t pair_q;

	assign elig = !cl_used[smp.cluster] && (reuse || !fl_used[smp.flash]);
	// strict compare keeps the earliest entry among equal scores
	assign take = smp_vld && elig && (!found_q || ($signed(smp.score) > $signed(pair_q.score)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clr) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pair_q <= smp;
		end
	end

	assign best.found = found_q;
	assign best.pair  = pair_q;

endmodule
`default_nettype wire

### sv/greedy_score_ordered_matcher.sv
`default_nettype none
// Greedy score-ordered matcher.
// Input channel (in_valid / in_stall) carries scored pairs, one transfer per
// cycle while loading. Pairs with score <= 0 are dropped; pairs beyond the
// 256-entry store are dropped and flagged on store_overflow.
// The transfer with set_end high closes the set. The block then stalls its
// input and runs matching passes: each pass reads the n stored pairs out of
// the pair memory, one per cycle, through one shared compare unit that keeps
// the best eligible pair. A set with m matches takes (m + 1) passes, after
// which loading resumes.
// Output channel (out_valid / out_stall) carries one result per match, the
// last one marked final_match; an empty set gives one no_match result.
// A stalled output holds its result; the sequencer waits at each further
// result until the output register is free.
// Config channel (cfg_valid / cfg_ready, always ready) writes
// allow_flash_reuse; write only while idle between sets.
// Reset clears the store count, used maps and flags and sets
// allow_flash_reuse to 1; no clearing pass is needed.
module greedy_score_ordered_matcher import gsm_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [CLUSTER_W-1:0]        cluster_id,
	input  wire logic [FLASH_W-1:0]          flash_idx,
	input  wire logic signed [SCORE_W-1:0]   pair_score,
	input  wire logic                        set_end,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [CLUSTER_W-1:0]             match_cluster,
	output logic [FLASH_W-1:0]               match_flash,
	output logic signed [SCORE_W-1:0]        match_score,
	output logic                             final_match,
	output logic                             no_match,
	output logic                             store_overflow,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic                        allow_flash_reuse
);

	state_t state_q;
	state_t state_d;

	logic                    reuse_q;
	logic [CNT_W-1:0]        count_q;
	logic                    ovf_q;
	logic [MAX_CLUSTERS-1:0] cl_used_q;
	logic [MAX_FLASHES-1:0]  fl_used_q;
	logic [CNT_W-1:0]        rd_addr_q;
	logic                    rd_vld_s1;
	pair_t                   rd_data_s1;
	logic                    pend_vld_q;
	pair_t                   pend_q;

	pair_t mem [MAX_PAIRS];

	logic  in_xfer;
	logic  keep;
	logic  full;
	logic  issue;
	logic  scan_done;
	logic  out_free;
	logic  advance;
	logic  set_clear;
	logic  out_load;
	logic  best_clr;
	pair_t in_pair;
	best_t best;

	assign cfg_ready = 1'b1;

	assign in_xfer = in_valid && !in_stall;
	assign keep    = (pair_score > 0) && (32'(cluster_id) < MAX_CLUSTERS) &&
		(32'(flash_idx) < MAX_FLASHES);
	assign full    = (count_q == CNT_W'(MAX_PAIRS));
	assign issue   = (state_q == ST_SCAN) && (rd_addr_q < count_q);
	assign scan_done = !issue && !rd_vld_s1;
	assign out_free  = !out_valid || !out_stall;

	assign in_pair.cluster = cluster_id;
	assign in_pair.flash   = flash_idx;
	assign in_pair.score   = pair_score;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_xfer && set_end) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (advance) state_d = ST_SCAN;
				else if (set_clear) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != ST_LOAD);
		advance   = (state_q == ST_DECIDE) && best.found && (!pend_vld_q || out_free);
		set_clear = (state_q == ST_DECIDE) && !best.found && out_free;
		out_load  = (state_q == ST_DECIDE) && out_free && (!best.found || pend_vld_q);
		best_clr  = ((state_q == ST_LOAD) && in_xfer && set_end) || advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reuse_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			reuse_q <= allow_flash_reuse;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && keep && !full) begin
			mem[count_q[ADDR_W-1:0]] <= in_pair;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_addr_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ovf_q      <= 1'b0;
			cl_used_q  <= '0;
			fl_used_q  <= '0;
			pend_vld_q <= 1'b0;
		end else if (set_clear) begin
			count_q    <= '0;
			ovf_q      <= 1'b0;
			cl_used_q  <= '0;
			fl_used_q  <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			if (in_xfer && keep) begin
				if (full) ovf_q <= 1'b1;
				else count_q <= count_q + 1'b1;
			end
			if (advance) begin
				cl_used_q[best.pair.cluster] <= 1'b1;
				fl_used_q[best.pair.flash]   <= 1'b1;
				pend_vld_q                   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pend_q <= best.pair;
		end
	end

	// walk the store once per pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (best_clr) rd_addr_q <= '0;
			else if (issue) rd_addr_q <= rd_addr_q + 1'b1;
		end
	end

	gsm_best_unit u_best (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (best_clr),
		.smp_vld (rd_vld_s1),
		.smp     (rd_data_s1),
		.cl_used (cl_used_q),
		.fl_used (fl_used_q),
		.reuse   (reuse_q),
		.best    (best)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			store_overflow <= ovf_q;
			if (pend_vld_q) begin
				match_cluster <= pend_q.cluster;
				match_flash   <= pend_q.flash;
				match_score   <= pend_q.score;
				final_match   <= !best.found;
				no_match      <= 1'b0;
			end else begin
				match_cluster <= '0;
				match_flash   <= '0;
				match_score   <= '0;
				final_match   <= 1'b1;
				no_match      <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### tb/sv/greedy_score_ordered_matcher_tb.sv
`timescale 1ns / 1ps
module greedy_score_ordered_matcher_tb import gsm_pkg::*;;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_ITEMS = 300;
	localparam int SETTLE_CYCLES = 12;

	typedef struct {
		logic [CLUSTER_W-1:0]      cluster;
		logic [FLASH_W-1:0]        flash;
		logic signed [SCORE_W-1:0] score;
		logic                      is_final;
		logic                      is_empty;
		logic                      ovf;
	} match_t;

	class match_scoreboard;
		pair_t  pairs[$];
		bit     overflow;
		bit     reuse;
		match_t expected[$];
		int     errors;
		int     results_seen;
		int     sets_closed;
		int     overflow_sets;
		int     pairs_taken;

		function new();
			overflow = 1'b0;
			reuse = 1'b1;
			errors = 0;
			results_seen = 0;
			sets_closed = 0;
			overflow_sets = 0;
			pairs_taken = 0;
		endfunction

		function void set_reuse(bit v);
			reuse = v;
		endfunction

		function string show(match_t m);
			return $sformatf("cluster %0d flash %0d score %0d final %0b empty %0b ovf %0b",
				m.cluster, m.flash, m.score, m.is_final, m.is_empty, m.ovf);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("ERROR: %s", msg);
		endfunction

		function void note_pair(pair_t p, bit closes);
			int                      order[$];
			logic [MAX_CLUSTERS-1:0] c_used;
			logic [MAX_FLASHES-1:0]  f_used;
			match_t                  held;
			bit                      have_held;
			int                      j;
			pair_t                   q;
			pairs_taken++;
			if (p.score > 0 && p.cluster < MAX_CLUSTERS && p.flash < MAX_FLASHES) begin
				if (pairs.size() < MAX_PAIRS)
					pairs.insert(pairs.size(), p);
				else
					overflow = 1'b1;
			end
			if (!closes)
				return;
			for (int i = 0; i < pairs.size(); i++) begin
				j = order.size();
				while (j > 0 && pairs[order[j-1]].score < pairs[i].score)
					j--;
				order.insert(j, i);
			end
			c_used = '0;
			f_used = '0;
			have_held = 1'b0;
			foreach (order[k]) begin
				q = pairs[order[k]];
				if (c_used[q.cluster])
					continue;
				if (!reuse && f_used[q.flash])
					continue;
				c_used[q.cluster] = 1'b1;
				f_used[q.flash] = 1'b1;
				if (have_held)
					expected.insert(expected.size(), held);
				held = '{q.cluster, q.flash, q.score, 1'b0, 1'b0, overflow};
				have_held = 1'b1;
			end
			if (have_held) begin
				held.is_final = 1'b1;
			end else begin
				held = '{'0, '0, '0, 1'b1, 1'b1, overflow};
			end
			expected.insert(expected.size(), held);
			if (overflow)
				overflow_sets++;
			sets_closed++;
			pairs.delete();
			overflow = 1'b0;
		endfunction

		function void check_result(match_t got);
			match_t want;
			results_seen++;
			if (expected.size() == 0) begin
				flag({"unexpected result ", show(got)});
				return;
			end
			want = expected.pop_front();
			if (got.cluster !== want.cluster || got.flash !== want.flash ||
					got.score !== want.score || got.is_final !== want.is_final ||
					got.is_empty !== want.is_empty || got.ovf !== want.ovf)
				flag({"mismatch expected ", show(want), " got ", show(got)});
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [CLUSTER_W-1:0]      cluster_id;
	logic [FLASH_W-1:0]        flash_idx;
	logic signed [SCORE_W-1:0] pair_score;
	logic                      set_end;
	logic                      out_valid;
	logic                      out_stall;
	logic [CLUSTER_W-1:0]      match_cluster;
	logic [FLASH_W-1:0]        match_flash;
	logic signed [SCORE_W-1:0] match_score;
	logic                      final_match;
	logic                      no_match;
	logic                      store_overflow;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic                      allow_flash_reuse;

	match_scoreboard sb;
	bit              tx_idle;
	bit              rx_idle;
	int              random_items;
	int              reuse_writes[2];
	int              cycle_count;

	greedy_score_ordered_matcher i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.cluster_id        (cluster_id),
		.flash_idx         (flash_idx),
		.pair_score        (pair_score),
		.set_end           (set_end),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.match_cluster     (match_cluster),
		.match_flash       (match_flash),
		.match_score       (match_score),
		.final_match       (final_match),
		.no_match          (no_match),
		.store_overflow    (store_overflow),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.allow_flash_reuse (allow_flash_reuse)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_pair(pair_t'{cluster_id, flash_idx, pair_score}, set_end);
			if (out_valid && !out_stall)
				sb.check_result(match_t'{match_cluster, match_flash, match_score,
					final_match, no_match, store_overflow});
		end
	end

	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = rx_idle ? $urandom_range(0, 17) : 0;
			repeat (hold) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ERROR: timeout after %0d cycles, %0d results outstanding",
			cycle_count, sb.expected.size());
		$display("Test completed with failures");
		$finish;
	end

	task automatic send_pair(input logic [CLUSTER_W-1:0] c, input logic [FLASH_W-1:0] f,
			input logic signed [SCORE_W-1:0] s, input bit closes);
		int gap;
		gap = tx_idle ? $urandom_range(0, 17) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		cluster_id <= c;
		flash_idx <= f;
		pair_score <= s;
		set_end <= closes;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reuse(input bit v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		allow_flash_reuse <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reuse(v);
		reuse_writes[v]++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_set(input int n);
		logic [CLUSTER_W-1:0]      c_mask;
		logic [FLASH_W-1:0]        f_mask;
		logic signed [SCORE_W-1:0] s;
		bit                        ties;
		case ($urandom_range(0, 2))
			0: c_mask = 5'h03;
			1: c_mask = 5'h0F;
			default: c_mask = '1;
		endcase
		case ($urandom_range(0, 2))
			0: f_mask = 6'h03;
			1: f_mask = 6'h0F;
			default: f_mask = '1;
		endcase
		ties = $urandom_range(0, 2) == 0;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 15))
				0: s = '0;
				1: s = 32'($urandom) | 32'h8000_0000;
				2: s = 32'h7FFF_FFFF;
				default: s = ties ? 32'($urandom_range(1, 4)) << 16 : 32'($urandom) & 32'h7FFF_FFFF;
			endcase
			send_pair(5'($urandom) & c_mask, 6'($urandom) & f_mask, s, i == n - 1);
			random_items++;
		end
	endtask

	initial begin
		int extra;
		int n;
		int r;
		int phase;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		cluster_id = '0;
		flash_idx = '0;
		pair_score = '0;
		set_end = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		allow_flash_reuse = 1'b1;
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		random_items = 0;
		reuse_writes[0] = 0;
		reuse_writes[1] = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		write_reuse(1'b1);
		send_pair(5'd0, 6'd0, 32'sd0, 1'b1);
		wait_drained();
		send_pair(5'd31, 6'd63, 32'h7FFF_FFFF, 1'b0);
		send_pair(5'd31, 6'd0, 32'sd1, 1'b0);
		send_pair(5'd0, 6'd63, 32'h8000_0000, 1'b0);
		send_pair(5'd5, 6'd63, 32'sd1, 1'b0);
		send_pair(5'd7, 6'd9, -32'sd1, 1'b1);
		wait_drained();
		write_reuse(1'b0);
		send_pair(5'd3, 6'd1, 32'h0001_0000, 1'b0);
		send_pair(5'd3, 6'd2, 32'h0001_0000, 1'b0);
		send_pair(5'd4, 6'd1, 32'h0001_0000, 1'b1);
		wait_drained();
		send_pair(5'd1, 6'd5, 32'h7FFF_FFFF, 1'b0);
		send_pair(5'd2, 6'd5, 32'h7FFF_FFFE, 1'b0);
		send_pair(5'd2, 6'd6, 32'sd3, 1'b1);
		wait_drained();
		send_pair(5'd10, 6'd10, -32'sd5, 1'b0);
		send_pair(5'd21, 6'd42, 32'h8000_0000, 1'b1);
		wait_drained();

		phase = 0;
		while (random_items < RANDOM_ITEMS || phase < 2) begin
			wait_drained();
			write_reuse($urandom_range(0, 1));
			tx_idle = phase != 0;
			rx_idle = phase != 0 && $urandom_range(0, 2) != 0;
			if (phase == 1) begin
				extra = $urandom_range(1, 8);
				for (int i = 0; i < MAX_PAIRS + extra; i++) begin
					if ($urandom_range(0, 15) == 0) begin
						send_pair(5'($urandom), 6'($urandom), -32'sd1, 1'b0);
						random_items++;
					end
					send_pair(5'($urandom), 6'($urandom),
						(32'($urandom) & 32'h7FFF_FFFF) | 32'd1, i == MAX_PAIRS + extra - 1);
					random_items++;
				end
			end else begin
				repeat ($urandom_range(4, 8)) begin
					r = $urandom_range(0, 19);
					if (r < 16)
						n = $urandom_range(1, 10);
					else if (r < 19)
						n = $urandom_range(11, 40);
					else
						n = $urandom_range(41, 72);
					send_random_set(n);
				end
			end
			phase++;
		end
		wait_drained();

		$display("Summary: %0d pairs in %0d sets, %0d results checked, %0d sets overflowed",
			sb.pairs_taken, sb.sets_closed, sb.results_seen, sb.overflow_sets);
		$display("Summary: flash reuse set off %0d times and on %0d times, %0d mismatches",
			reuse_writes[0], reuse_writes[1], sb.errors);
		if (sb.errors == 0 && sb.expected.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
